@@ sv/wbds_pkg.sv @@
`default_nettype none

package wbds_pkg;

	// fixed field widths
	localparam int IDX_W   = 9;
	localparam int ENTRY_W = 32;
	localparam int LEAST_W = 41;
	localparam int RBAND_W = 10;
	localparam int OP_W    = 2;
	localparam int CFG_W   = 2;

	// parameter defaults
	localparam int BAND_COUNT_DEF    = 512;
	localparam int MASS_BITS_DEF     = 32;
	localparam int FRACTION_BITS_DEF = 24;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_DRAW  = 2'd1;
	localparam logic [OP_W-1:0] OP_SWEEP = 2'd2;

	// register indexes
	localparam logic [CFG_W-1:0] CFG_FIRST_BAND = 2'd0;
	localparam logic [CFG_W-1:0] CFG_LAST_BAND  = 2'd1;
	localparam logic [CFG_W-1:0] CFG_LEAST_MASS = 2'd2;

	// register reset values
	localparam logic [IDX_W-1:0]   FIRST_BAND_RST = 9'd3;
	localparam logic [IDX_W-1:0]   LAST_BAND_RST  = 9'd500;
	localparam logic [LEAST_W-1:0] LEAST_MASS_RST = '0;

endpackage

`default_nettype wire

@@ sv/wbds_ram.sv @@
`default_nettype none

module wbds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/weighted_band_draw_and_sweep.sv @@
`default_nettype none

// Weighted band draw and sweep. A table of BAND_COUNT mass entries lives in one
// single-port-read RAM; start is taken only while busy is low, and every item gives
// one result on result_valid for exactly one cycle, with no way for the receiver to
// hold it off. A load (and the unused op code) answers in the cycle after the start
// transfer, and busy never rises. A sweep streams one band per cycle through the RAM
// read port, clearing each band as its data returns. A draw makes two streaming
// passes through the same read port plus a shift-add multiply of one fraction bit per
// cycle. All sums, compares, multiply steps and remainder subtracts share one
// adder/subtractor under the sequencer, so the RAM port and that adder set the pace.
// After reset the block writes zeros through the whole table with busy high;
// configuration writes are taken during that pass and always (cfg_ready is tied
// high). Write configuration only while the block is idle.
module weighted_band_draw_and_sweep #(
	parameter int BAND_COUNT    = wbds_pkg::BAND_COUNT_DEF,
	parameter int MASS_BITS     = wbds_pkg::MASS_BITS_DEF,
	parameter int FRACTION_BITS = wbds_pkg::FRACTION_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// command channel
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [wbds_pkg::OP_W-1:0]      op,
	input  wire logic [wbds_pkg::IDX_W-1:0]     band_index,
	input  wire logic [wbds_pkg::IDX_W-1:0]     upper_band,
	input  wire logic [wbds_pkg::ENTRY_W-1:0]   entry_mass,
	input  wire logic [FRACTION_BITS-1:0]       random_fraction,
	// result channel
	output logic                                result_valid,
	output logic      [wbds_pkg::RBAND_W-1:0]   result_band,
	output logic      [wbds_pkg::LEAST_W-1:0]   result_mass,
	output logic                                empty_flag,
	// configuration channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [wbds_pkg::CFG_W-1:0]     cfg_index,
	input  wire logic [wbds_pkg::LEAST_W-1:0]   cfg_data
);

	localparam int AW    = $clog2(BAND_COUNT);
	// band index width that also holds last band plus one
	localparam int IW    = ((AW > wbds_pkg::IDX_W) ? AW : wbds_pkg::IDX_W) + 1;
	localparam int SUM_W = MASS_BITS + AW;
	localparam int CMP_W = (SUM_W > wbds_pkg::LEAST_W) ? SUM_W : wbds_pkg::LEAST_W;
	localparam int ALU_W = CMP_W + 1;
	localparam int CNT_W = $clog2(FRACTION_BITS);

	localparam logic [IW-1:0]    TOP_MAX    = IW'(BAND_COUNT - 1);
	localparam logic [IW-1:0]    LOAD_LIMIT = IW'(BAND_COUNT);
	localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(FRACTION_BITS - 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SUM   = 6'b000100,
		S_CHK   = 6'b001000,
		S_MUL   = 6'b010000,
		S_SRCH  = 6'b100000
	} state_t;

	// control state
	state_t                       state_q;
	logic [IW-1:0]                rd_q;
	logic                         dv_s1;
	logic                         strobe_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [wbds_pkg::IDX_W-1:0]   first_band_q;
	logic [wbds_pkg::IDX_W-1:0]   last_band_q;
	logic [wbds_pkg::LEAST_W-1:0] least_mass_q;

	// payload
	logic [IW-1:0]                didx_s1;
	logic [IW-1:0]                end_q;
	logic [IW-1:0]                walk_q;
	logic [wbds_pkg::OP_W-1:0]    op_q;
	logic [FRACTION_BITS-1:0]     frac_q;
	logic [CMP_W-1:0]             acc_q;
	logic [CMP_W-1:0]             prod_q;
	logic [CMP_W-1:0]             rem_q;
	logic [wbds_pkg::RBAND_W-1:0] res_band_q;
	logic [wbds_pkg::LEAST_W-1:0] res_mass_q;
	logic                         res_empty_q;

	// table port
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [MASS_BITS-1:0]         ram_wdata;
	logic [MASS_BITS-1:0]         ram_rdata;

	// shared adder/subtractor
	logic [CMP_W-1:0]             alu_a;
	logic [CMP_W-1:0]             alu_b;
	logic                         alu_sub;
	logic [ALU_W-1:0]             alu_res;
	logic                         borrow;

	logic                         accept;
	logic                         issue;
	logic                         pass_done;
	logic [IW-1:0]                first_ext;
	logic [IW-1:0]                top_band;
	logic [IW-1:0]                sweep_lo;
	logic [IW-1:0]                sweep_hi;
	logic [CMP_W-1:0]             data_ext;

	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign cfg_ready    = 1'b1;
	assign result_valid = strobe_q;
	assign result_band  = res_band_q;
	assign result_mass  = res_mass_q;
	assign empty_flag   = res_empty_q;

	// active range, with the outer edge clamped to the table
	assign first_ext = IW'(first_band_q);
	assign top_band  = (IW'(last_band_q) > TOP_MAX) ? TOP_MAX : IW'(last_band_q);
	assign sweep_lo  = (IW'(band_index) < first_ext) ? first_ext : IW'(band_index);
	assign sweep_hi  = (IW'(upper_band) > top_band) ? top_band : IW'(upper_band);

	// read one band a cycle; a draw walk stops reading once the remainder hits zero
	assign issue     = ((state_q == S_SUM) || ((state_q == S_SRCH) && (rem_q != '0)))
		&& (rd_q <= end_q);
	assign pass_done = !issue && !dv_s1;
	assign data_ext  = CMP_W'(ram_rdata);

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_SUM: begin
				alu_a = acc_q;
				alu_b = data_ext;
			end
			S_CHK: begin
				alu_a   = acc_q;
				alu_b   = CMP_W'(least_mass_q);
				alu_sub = 1'b1;
			end
			S_MUL: begin
				alu_a = prod_q;
				alu_b = frac_q[0] ? acc_q : '0;
			end
			S_SRCH: begin
				alu_a   = rem_q;
				alu_b   = data_ext;
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
		: ({1'b0, alu_a} + {1'b0, alu_b});
	// carry on add, negative result on subtract
	assign borrow  = alu_res[ALU_W-1];

	// write port: clearing pass, load, or zeroing each swept band as its data returns
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_q[AW-1:0];
		ram_wdata = '0;
		priority if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (accept && (op == wbds_pkg::OP_LOAD) && (IW'(band_index) < LOAD_LIMIT)) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(band_index);
			ram_wdata = MASS_BITS'(entry_mass);
		end else if ((state_q == S_SUM) && (op_q == wbds_pkg::OP_SWEEP) && dv_s1) begin
			ram_we    = 1'b1;
			ram_waddr = didx_s1[AW-1:0];
		end else begin
			// nothing to write this cycle
			ram_we = 1'b0;
		end
	end

	wbds_ram #(
		.WIDTH (MASS_BITS),
		.DEPTH (BAND_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (rd_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// sequencer and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			rd_q         <= '0;
			dv_s1        <= 1'b0;
			strobe_q     <= 1'b0;
			cnt_q        <= '0;
			first_band_q <= wbds_pkg::FIRST_BAND_RST;
			last_band_q  <= wbds_pkg::LAST_BAND_RST;
			least_mass_q <= wbds_pkg::LEAST_MASS_RST;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					wbds_pkg::CFG_FIRST_BAND: first_band_q <= cfg_data[wbds_pkg::IDX_W-1:0];
					wbds_pkg::CFG_LAST_BAND:  last_band_q  <= cfg_data[wbds_pkg::IDX_W-1:0];
					wbds_pkg::CFG_LEAST_MASS: least_mass_q <= cfg_data;
					default: begin
						// no register here: drop the transfer
					end
				endcase
			end

			strobe_q <= 1'b0;
			dv_s1    <= issue;

			unique case (state_q)
				S_CLEAR: begin
					// zero one entry a cycle until the whole table is clean
					if (rd_q == TOP_MAX) begin
						state_q <= S_IDLE;
					end else begin
						rd_q <= rd_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							wbds_pkg::OP_DRAW: begin
								rd_q    <= first_ext;
								state_q <= S_SUM;
							end
							wbds_pkg::OP_SWEEP: begin
								rd_q    <= sweep_lo;
								state_q <= S_SUM;
							end
							default: begin
								// load and the unused code answer at once
								strobe_q <= 1'b1;
							end
						endcase
					end
				end
				S_SUM: begin
					if (issue) begin
						rd_q <= rd_q + 1'b1;
					end
					if (pass_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					cnt_q <= '0;
					if ((op_q == wbds_pkg::OP_DRAW) && !borrow) begin
						state_q <= S_MUL;
					end else begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						rd_q    <= first_ext;
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (issue) begin
						rd_q <= rd_q + 1'b1;
					end
					if (pass_done) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		didx_s1 <= rd_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q        <= op;
					frac_q      <= random_fraction;
					acc_q       <= '0;
					end_q       <= (op == wbds_pkg::OP_SWEEP) ? sweep_hi : top_band;
					res_band_q  <= '0;
					res_mass_q  <= '0;
					res_empty_q <= 1'b0;
				end
			end
			S_SUM: begin
				if (dv_s1) begin
					acc_q <= alu_res[CMP_W-1:0];
				end
			end
			S_CHK: begin
				// a total below the threshold is exhausted (draw) or empty (sweep)
				prod_q      <= '0;
				res_band_q  <= '0;
				res_empty_q <= borrow;
				res_mass_q  <= ((op_q == wbds_pkg::OP_SWEEP) && !borrow)
					? acc_q[wbds_pkg::LEAST_W-1:0] : '0;
			end
			S_MUL: begin
				// shift-add, fraction LSB first; the dropped bits give the floor
				prod_q <= alu_res[ALU_W-1:1];
				frac_q <= frac_q >> 1;
				if (cnt_q == CNT_LAST) begin
					rem_q  <= alu_res[ALU_W-1:1];
					walk_q <= first_ext;
				end
			end
			S_SRCH: begin
				if (dv_s1 && (rem_q != '0)) begin
					// a band at least as heavy as the remainder ends the walk
					rem_q  <= borrow ? '0 : alu_res[CMP_W-1:0];
					walk_q <= walk_q + 1'b1;
				end
				if (pass_done) begin
					res_band_q  <= walk_q[wbds_pkg::RBAND_W-1:0];
					res_mass_q  <= '0;
					res_empty_q <= 1'b0;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// read data only returns during a streaming pass
	a_read_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		dv_s1 |-> ((state_q == S_SUM) || (state_q == S_SRCH)))
		else $error("table read data outside a pass");

	// the draw target never exceeds the total it scales
	a_prod_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (prod_q <= acc_q))
		else $error("scaled target above total");

	// the walk remainder only shrinks
	a_rem_falls: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_SRCH) && $past(state_q == S_SRCH)) |-> (rem_q <= $past(rem_q)))
		else $error("walk remainder grew");

	// a draw never answers in the cycle after its start transfer
	a_draw_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == wbds_pkg::OP_DRAW)) |=> !result_valid)
		else $error("draw result too early");

endmodule

`default_nettype wire
